// ===== sv/ioset_pkg.sv =====
// shared types, sizes and opcodes for the insertion-ordered integer set
package ioset_pkg;

    // store size and the widths that follow from it
    localparam int SET_CAPACITY = 16;
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    // opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // command word
    typedef struct packed {
        logic [1:0]   opcode;
        logic signed [31:0] value;
    } t_set_req;

    // result word
    typedef struct packed {
        logic       ok;
        logic       full_reject;
        logic [4:0] member_count;
    } t_set_rsp;

endpackage

// ===== sv/insertion_ordered_int_set_top.sv =====
// insertion-ordered set of distinct 32-bit integers with one shared comparator
//
// Each command word (add, remove, membership query, clear) is taken at a clock
// edge where start is high and busy is low; busy then stays high until the
// result word appears on o_rsp, marked by o_done for exactly one cycle (clear
// never raises busy). The receiver cannot stall: o_done is a strobe, while
// o_rsp holds the word until the next result. Members sit packed in
// insertion order in a 16-entry memory with a registered read port, and a
// single comparator walks them one entry per cycle. Add and query stop at the
// first match or after the last member. Remove of a member stops at the match
// and then shifts each later member down one place through the same memory
// port; remove of an absent value stops after the last member. Clear answers
// on the cycle after acceptance. Reset empties the set at once.
module insertion_ordered_int_set_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  ioset_pkg::t_set_req i_req,
    output logic               busy,
    output logic               o_done,
    output ioset_pkg::t_set_rsp o_rsp
);
    import ioset_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_sh_v, n_sh_v;
    logic [1:0]       r_op, n_op;
    logic [31:0]      r_value, n_value;
    logic             r_done, n_done;
    t_set_rsp         r_rsp, n_rsp;

    // member store and its ports
    logic [31:0]      mem [SET_CAPACITY];
    logic [31:0]      r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [IDX_W-1:0] rd_addr;

    logic             hit;
    logic             accept;

    assign accept  = start && !busy;
    assign rd_addr = r_idx[IDX_W-1:0];
    // the word read last cycle belongs to position r_idx - 1
    assign hit     = (r_idx != '0) && (r_rdata == r_value);

    // sequencer and result assembly
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_sh_v    = r_sh_v;
        n_op      = r_op;
        n_value   = r_value;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = r_value;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_req.opcode;
                    n_value = i_req.value;
                    n_idx   = '0;
                    if (i_req.opcode == OP_CLEAR) begin
                        n_count                  = '0;
                        n_done                   = 1'b1;
                        n_rsp.ok                 = 1'b1;
                        n_rsp.full_reject        = 1'b0;
                        n_rsp.member_count       = '0;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    if (r_op == OP_REMOVE) begin
                        // r_idx already points one past the match
                        n_sh_v  = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_state            = S_IDLE;
                        n_done             = 1'b1;
                        n_rsp.ok           = (r_op == OP_QUERY);
                        n_rsp.full_reject  = 1'b0;
                        n_rsp.member_count = 5'(r_count);
                    end
                end else if (r_idx == r_count) begin
                    // every member compared, no match
                    n_state           = S_IDLE;
                    n_done            = 1'b1;
                    n_rsp.ok          = 1'b0;
                    n_rsp.full_reject = 1'b0;
                    if (r_op == OP_ADD) begin
                        if (r_count < CNT_W'(SET_CAPACITY)) begin
                            mem_we   = 1'b1;
                            n_count  = r_count + 1'b1;
                            n_rsp.ok = 1'b1;
                        end else begin
                            n_rsp.full_reject = 1'b1;
                        end
                    end
                    n_rsp.member_count = 5'(n_count);
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SHIFT: begin
                // move the word read last cycle down one place
                if (r_sh_v) begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(r_idx - CNT_W'(2));
                    mem_wdata = r_rdata;
                end
                if (r_idx == r_count) begin
                    n_state            = S_IDLE;
                    n_count            = r_count - 1'b1;
                    n_done             = 1'b1;
                    n_rsp.ok           = 1'b1;
                    n_rsp.full_reject  = 1'b0;
                    n_rsp.member_count = 5'(n_count);
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_sh_v = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_sh_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_idx   <= n_idx;
            r_sh_v  <= n_sh_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_rsp   <= n_rsp;
    end

    // member memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SET_CAPACITY))
        else $error("member count beyond capacity");

    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("sequencer finished without a result strobe");

    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.member_count == 5'(r_count)))
        else $error("reported count differs from stored count");

    a_shift_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> ((r_idx != '0) && (r_idx <= r_count)))
        else $error("shift pointer outside the occupied entries");

    a_reject_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.full_reject) |-> (!o_rsp.ok
            && r_count == CNT_W'(SET_CAPACITY)))
        else $error("full reject with ok set or store not full");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the insertion-ordered integer set, with its own set predictor
`timescale 1ns / 100ps

module tb_top;
    import ioset_pkg::*;

    // cycles with no word moving before the run is abandoned
    localparam int WATCHDOG_LIMIT = 500;
    // longest remove walk plus some slack
    localparam int DRAIN_CYCLES = 2 * SET_CAPACITY + 8;
    localparam int MAX_GAP = 30;
    localparam int POOL_SIZE = 24;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    t_set_req i_req = '0;
    logic     busy;
    logic     o_done;
    t_set_rsp o_rsp;

    // predicted set contents, oldest member first
    logic [31:0] members[$];
    // result words still to arrive
    t_set_rsp    pending_rsp[$];
    int          err_cnt = 0;
    int          stall_cycles = 0;
    int          idle_pct = 0;
    logic [31:0] value_pool[POOL_SIZE];

    always #1 i_clk = ~i_clk;

    insertion_ordered_int_set_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // position of a value among the members, -1 if absent
    function automatic int find_member(logic [31:0] v);
        foreach (members[i]) begin
            if (members[i] == v) return i;
        end
        return -1;
    endfunction

    // apply one command word to the predicted set and return its result word
    function automatic t_set_rsp apply_set_op(t_set_req w);
        t_set_rsp r;
        int       pos;
        r = '0;
        pos = find_member(w.value);
        case (w.opcode)
            OP_ADD: begin
                if (pos < 0) begin
                    if (members.size() < SET_CAPACITY) begin
                        members.push_back(w.value);
                        r.ok = 1'b1;
                    end else begin
                        r.full_reject = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (pos >= 0) begin
                    members.delete(pos);
                    r.ok = 1'b1;
                end
            end
            OP_QUERY: begin
                r.ok = (pos >= 0);
            end
            default: begin
                members.delete();
                r.ok = 1'b1;
            end
        endcase
        r.member_count = 5'(members.size());
        return r;
    endfunction

    // result check, prediction on acceptance, and watchdog
    always @(posedge i_clk) begin
        t_set_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_rsp.size() == 0) begin
                    $error("result word with nothing expected: %p", o_rsp);
                    err_cnt++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.ok !== want.ok) begin
                        $error("ok: expected %0b, got %0b", want.ok, o_rsp.ok);
                        err_cnt++;
                    end
                    if (o_rsp.full_reject !== want.full_reject) begin
                        $error("full_reject: expected %0b, got %0b",
                               want.full_reject, o_rsp.full_reject);
                        err_cnt++;
                    end
                    if (o_rsp.member_count !== want.member_count) begin
                        $error("member_count: expected %0d, got %0d",
                               want.member_count, o_rsp.member_count);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) pending_rsp.push_back(apply_set_op(i_req));
            if (o_done || (start && !busy)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("insertion_ordered_int_set_top test failed");
                $finish;
            end
        end
    end

    // send one command word, after a random idle gap in the idling phases
    task automatic send_word(input logic [1:0] op, input logic [31:0] v);
        int gap;
        gap = 0;
        while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= {op, v};
        do @(posedge i_clk); while (busy);
    endtask

    // extremes, every opcode and the corner cases of add, remove and clear
    task automatic test_directed();
        idle_pct = 0;
        send_word(OP_CLEAR, 32'h0);
        send_word(OP_QUERY, 32'h0);
        send_word(OP_REMOVE, 32'h1234_5678);
        send_word(OP_ADD, 32'h8000_0000);
        send_word(OP_ADD, 32'h7FFF_FFFF);
        send_word(OP_ADD, 32'h7FFF_FFFF);
        send_word(OP_QUERY, 32'h8000_0000);
        send_word(OP_REMOVE, 32'h8000_0000);
        // fill the store up to capacity, the last value being all ones
        for (int i = 1; i < SET_CAPACITY; i++) begin
            send_word(OP_ADD, 32'(i * 32'h1111_1111));
        end
        send_word(OP_ADD, 32'h0);
        send_word(OP_ADD, 32'h7FFF_FFFF);
        // last entry, then one from the middle
        send_word(OP_REMOVE, 32'((SET_CAPACITY - 1) * 32'h1111_1111));
        send_word(OP_REMOVE, 32'h3333_3333);
        send_word(OP_CLEAR, 32'hFFFF_FFFF);
    endtask

    // random commands, mostly on a small pool of values so that hits are common
    task automatic test_random(input int n_items, input int pct);
        int          sel;
        logic [1:0]  op;
        logic [31:0] v;
        idle_pct = pct;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) op = OP_ADD;
            else if (sel < 70) op = OP_REMOVE;
            else if (sel < 98) op = OP_QUERY;
            else op = OP_CLEAR;
            if ($urandom_range(99) < 80) v = value_pool[$urandom_range(POOL_SIZE - 1)];
            else v = $urandom;
            send_word(op, v);
        end
    endtask

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(270, 0);
        test_random(270, 73);
        test_random(270, 36);
        start <= 1'b0;

        // let every result word arrive, then watch for strays
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("insertion_ordered_int_set_top test passed");
        end else begin
            $display("insertion_ordered_int_set_top test failed");
        end
        $finish;
    end

endmodule
